// ===== rtl/ckmd_pkg.sv =====
// ----------------------------------------------------------------------------
// ckmd_pkg
// Shared types and constants of the clock multiplier / divider.
// ----------------------------------------------------------------------------
package ckmd_pkg;

    localparam int RATIO_W     = 6;
    localparam int MAG_W       = 5;
    localparam int MIN_GATE_W  = 16;
    localparam int DT_W        = 4;
    localparam int OUT_W       = 24;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [MAG_W-1:0]      MAX_RATIO      = 5'd16;
    localparam logic [RATIO_W-1:0]    RATIO_RESET    = 6'd1;
    localparam logic [MIN_GATE_W-1:0] MIN_GATE_RESET = 16'd48;
    localparam logic [OUT_W-1:0]      OUT_PERIOD_MAX = 24'hFFFFFF;

    localparam logic [CFG_INDEX_W-1:0] REG_RATIO    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_GATE = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/clock_multiplier_divider.sv =====
// ----------------------------------------------------------------------------
// clock_multiplier_divider
// Measures the base clock period from pulse spacing and derives a divided or
// multiplied gate, reporting the derived period.
// ----------------------------------------------------------------------------
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_stall, clock_pulse,          | to block
//         | elapsed_ticks                             |
// out     | out_valid, out_stall, gate,               | from block
//         | effective_period, period_known            |
// cfg     | cfg_we, cfg_index, cfg_data               | to block
//
// Each transaction runs the shared one-bit-per-cycle divider for period and
// phase; the period division is skipped with no multiply, both where no
// period is known, and the phase division where the gate is low by range.
// in_stall is high from acceptance until the result enters the output
// register; a stalled result holds the block before that load.
// Reset clears all timing state and loads ratio 1, minimum gate 48.
// ----------------------------------------------------------------------------
module clock_multiplier_divider #(
    parameter int TIME_WIDTH = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 clock_pulse,
    input  logic [ckmd_pkg::DT_W-1:0]            elapsed_ticks,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 gate,
    output logic [ckmd_pkg::OUT_W-1:0]           effective_period,
    output logic                                 period_known,
    input  logic                                 cfg_we,
    input  logic [ckmd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ckmd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int TW = TIME_WIDTH;
    localparam int W  = TIME_WIDTH + 4;
    localparam int PW = (W > ckmd_pkg::OUT_W) ? W : ckmd_pkg::OUT_W;
    localparam int MW = ckmd_pkg::MAG_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_PLAN  = 3'd2;
    localparam logic [2:0] S_DIVP  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_MOD   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [ckmd_pkg::RATIO_W-1:0]    ratio_reg;
    logic [ckmd_pkg::MIN_GATE_W-1:0] min_gate_reg;

    logic          started_reg, started_next;
    logic [TW-1:0] slp_reg, slp_next;
    logic [TW-1:0] ip_reg, ip_next;
    logic          ipv_reg, ipv_next;
    logic [MW-1:0] dc_reg, dc_next;
    logic [W-1:0]  prog_reg, prog_next;

    logic [W-1:0]  d_reg, d_next;
    logic [W-1:0]  p_reg, p_next;
    logic          res_gate_reg, res_gate_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          gate_reg, gate_next;
    logic [ckmd_pkg::OUT_W-1:0]    eff_reg, eff_next;
    logic                          known_reg, known_next;

    logic [ckmd_pkg::RATIO_W-1:0] mag_raw;
    logic [MW-1:0] mag;
    logic [MW-1:0] division;
    logic [MW-1:0] mult;
    logic          ratio_neg;

    logic [TW-1:0] slp_base;
    logic [TW:0]   slp_sum;
    logic [W:0]    prog_sum;
    logic [MW:0]   dc_inc;

    logic                  div_start;
    logic [W-1:0]          div_dividend;
    logic [W-1:0]          div_divisor;
    logic [W-1:0]          div_quotient;
    logic [W-1:0]          div_remainder;
    ckmd_pkg::div_status_t div_status;

    logic [PW-1:0] p_wide;
    logic          accept;
    logic          out_free;

    // ratio decode
    always_comb
    begin
        ratio_neg = ratio_reg[ckmd_pkg::RATIO_W-1];
        mag_raw   = ratio_neg ? (~ratio_reg + 6'd1) : ratio_reg;
        mag       = (mag_raw > 6'(ckmd_pkg::MAX_RATIO)) ? ckmd_pkg::MAX_RATIO : mag_raw[MW-1:0];
        division  = ratio_neg ? mag : MW'(1);
        mult      = (!ratio_neg && mag_raw != '0) ? mag : MW'(1);
    end

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // per-transaction timing update
    always_comb
    begin
        started_next = started_reg;
        slp_next     = slp_reg;
        ip_next      = ip_reg;
        ipv_next     = ipv_reg;
        dc_next      = dc_reg;
        prog_next    = prog_reg;
        slp_base     = slp_reg;
        slp_sum      = '0;
        prog_sum     = {1'b0, prog_reg} + (W+1)'(elapsed_ticks);
        dc_inc       = {1'b0, dc_reg} + (MW+1)'(1);

        if (accept)
        begin
            if (clock_pulse)
            begin
                if (started_reg && slp_reg != '0)
                begin
                    ip_next  = slp_reg;
                    ipv_next = 1'b1;
                end
                slp_base     = '0;
                started_next = 1'b1;
            end
            slp_sum = {1'b0, slp_base} + (TW+1)'(elapsed_ticks);
            if (started_next)
            begin
                slp_next = slp_sum[TW] ? '1 : slp_sum[TW-1:0];
                if (clock_pulse && dc_reg == '0)
                begin
                    prog_next = '0;
                end
                else
                begin
                    prog_next = prog_sum[W] ? '1 : prog_sum[W-1:0];
                end
                if (clock_pulse)
                begin
                    dc_next = (dc_inc >= {1'b0, division}) ? '0 : dc_inc[MW-1:0];
                end
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        d_next         = d_reg;
        p_next         = p_reg;
        res_gate_next  = res_gate_reg;
        div_start      = 1'b0;
        div_dividend   = prog_reg;
        div_divisor    = p_reg;
        out_valid_next = out_valid_reg && out_stall;
        gate_next      = gate_reg;
        eff_next       = eff_reg;
        known_next     = known_reg;
        p_wide         = PW'(p_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                d_next     = W'(ip_reg) * W'(division);
                state_next = S_PLAN;
            end
            S_PLAN:
            begin
                if (!ipv_reg)
                begin
                    p_next        = '0;
                    res_gate_next = 1'b0;
                    state_next    = S_DONE;
                end
                else if (mult == MW'(1))
                begin
                    p_next     = (d_reg == '0) ? W'(1) : d_reg;
                    state_next = S_CHECK;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = d_reg;
                    div_divisor  = W'(mult);
                    state_next   = S_DIVP;
                end
            end
            S_DIVP:
            begin
                if (div_status.done)
                begin
                    p_next     = (div_quotient == '0) ? W'(1) : div_quotient;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (started_reg && prog_reg < d_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_MOD;
                end
                else
                begin
                    res_gate_next = 1'b0;
                    state_next    = S_DONE;
                end
            end
            S_MOD:
            begin
                if (div_status.done)
                begin
                    res_gate_next = ({div_remainder, 1'b0} <= {1'b0, p_reg})
                                 || (div_remainder <= W'(min_gate_reg));
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    gate_next      = res_gate_reg;
                    known_next     = ipv_reg;
                    eff_next       = (p_wide > PW'(ckmd_pkg::OUT_PERIOD_MAX))
                                   ? ckmd_pkg::OUT_PERIOD_MAX
                                   : p_wide[ckmd_pkg::OUT_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    ckmd_divider #(
        .W (W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .status    (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ratio_reg     <= ckmd_pkg::RATIO_RESET;
            min_gate_reg  <= ckmd_pkg::MIN_GATE_RESET;
            started_reg   <= 1'b0;
            slp_reg       <= '0;
            ip_reg        <= '0;
            ipv_reg       <= 1'b0;
            dc_reg        <= '0;
            prog_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            slp_reg       <= slp_next;
            ip_reg        <= ip_next;
            ipv_reg       <= ipv_next;
            dc_reg        <= dc_next;
            prog_reg      <= prog_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ckmd_pkg::REG_RATIO:
                    begin
                        ratio_reg <= cfg_data[ckmd_pkg::RATIO_W-1:0];
                    end
                    ckmd_pkg::REG_MIN_GATE:
                    begin
                        min_gate_reg <= cfg_data[ckmd_pkg::MIN_GATE_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg        <= d_next;
        p_reg        <= p_next;
        res_gate_reg <= res_gate_next;
        gate_reg     <= gate_next;
        eff_reg      <= eff_next;
        known_reg    <= known_next;
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign gate             = gate_reg;
    assign effective_period = eff_reg;
    assign period_known     = known_reg;

    // divider finishes only inside a wait state
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == S_DIVP || state_reg == S_MOD))
        else $error("divider done outside a wait state");

    // no divider run left over when idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_status.busy)
        else $error("divider busy while idle");

    // no period known means no gate and zero period
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !known_reg) |-> (!gate_reg && eff_reg == '0))
        else $error("result without period carries gate or period");

endmodule

// ===== rtl/ckmd_divider.sv =====
// ----------------------------------------------------------------------------
// ckmd_divider
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module ckmd_divider #(
    parameter int W = 28
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [W-1:0]          dividend,
    input  logic [W-1:0]          divisor,
    output logic [W-1:0]          quotient,
    output logic [W-1:0]          remainder,
    output ckmd_pkg::div_status_t status
);

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dsr_reg;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        ge      = (shifted >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

// ===== dv/clock_multiplier_divider_tb.sv =====
// ----------------------------------------------------------------------------
// clock_multiplier_divider_tb
// Self-checking bench for the clock multiplier / divider. A directed table
// covers reset behaviour, zero elapsed time, the saturating ratio extremes and
// the one-tick derived period. Randomised pulse trains then run under several
// ratio and minimum-gate settings with random idling on both channels. Typed
// directed rows are checked against the table; every other result against an
// in-bench model of the period measurement and gate logic.
// ----------------------------------------------------------------------------
module clock_multiplier_divider_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DT_W        = ckmd_pkg::DT_W;
    localparam int RATIO_W     = ckmd_pkg::RATIO_W;
    localparam int MIN_GATE_W  = ckmd_pkg::MIN_GATE_W;
    localparam int MAG_W       = ckmd_pkg::MAG_W;
    localparam int OUT_W       = ckmd_pkg::OUT_W;
    localparam int CFG_INDEX_W = ckmd_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = ckmd_pkg::CFG_DATA_W;

    localparam int              TIME_W         = 24;
    localparam longint unsigned TIME_MAX       = (64'd1 << TIME_W) - 1;
    localparam longint unsigned PROG_MAX       = (64'd1 << (TIME_W + 4)) - 1;
    localparam int              HOLD_CYCLES    = 600;
    localparam int              WATCHDOG_LIMIT = 5000;
    localparam int              SETTLE_CYCLES  = 80;
    localparam int              N_PHASES       = 10;
    localparam int              PHASE_ITEMS    = 198;
    localparam int              REPORT_MAX     = 10;
    localparam int              N_DIRECTED     = 25;

    typedef struct packed {
        logic             gate;
        logic [OUT_W-1:0] period;
        logic             known;
    } result_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic                  pulse;
        logic [DT_W-1:0]       dt;
        logic [RATIO_W-1:0]    ratio_v;
        logic [MIN_GATE_W-1:0] min_gate_v;
        result_t               want;
    } plan_row_t;

    // ratio extremes at both ends: most negative saturates divide, 31 saturates multiply
    localparam logic [RATIO_W-1:0] PHASE_RATIO [7] =
        '{6'h20, 6'h30, 6'h3F, 6'h00, 6'h01, 6'h10, 6'h1F};
    localparam logic [MIN_GATE_W-1:0] PHASE_MIN_GATE [7] =
        '{16'd0, 16'hFFFF, 16'd48, 16'd3, 16'hFFFF, 16'd0, 16'd1};

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   clock_pulse;
    logic [DT_W-1:0]        elapsed_ticks;
    logic                   out_valid;
    logic                   out_stall;
    logic                   gate;
    logic [OUT_W-1:0]       effective_period;
    logic                   period_known;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // model state
    logic signed [RATIO_W-1:0] ratio_q;
    logic [MIN_GATE_W-1:0]     min_gate_q;
    logic                      started_q;
    logic [TIME_W-1:0]         since_pulse_q;
    logic [TIME_W-1:0]         in_period_q;
    logic                      period_valid_q;
    logic [MAG_W-1:0]          div_count_q;
    logic [TIME_W+3:0]         progress_q;

    result_t   expected_clock_out [$];
    plan_row_t directed_plan [N_DIRECTED];

    int idle_pct;
    int stall_pct;
    int hold_req;
    int items_in;
    int results_checked;
    int settings_done;
    int holds_done;
    int mismatches;
    int gate_high_seen;
    int longest_period_seen;
    int quiet_cycles;

    clock_multiplier_divider #(
        .TIME_WIDTH(TIME_W)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .clock_pulse     (clock_pulse),
        .elapsed_ticks   (elapsed_ticks),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .gate            (gate),
        .effective_period(effective_period),
        .period_known    (period_known),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint unsigned sat_sum(input longint unsigned a,
                                                input longint unsigned b,
                                                input longint unsigned lim);
        return (a + b > lim) ? lim : a + b;
    endfunction

    function automatic result_t derive_gate(input logic pulse, input logic [DT_W-1:0] dt);
        int              rv;
        longint unsigned mag;
        longint unsigned division;
        longint unsigned mult;
        longint unsigned divided;
        longint unsigned period;
        longint unsigned r;
        result_t         res;
        rv = int'(ratio_q);
        mag = 64'((rv < 0) ? -rv : rv);
        if (mag > 64'(ckmd_pkg::MAX_RATIO))
        begin
            mag = 64'(ckmd_pkg::MAX_RATIO);
        end
        division = (rv < 0) ? mag : 64'd1;
        mult     = (rv > 0) ? mag : 64'd1;
        divided  = 0;
        period   = 0;
        res      = '0;
        if (pulse)
        begin
            if (started_q && since_pulse_q != 0)
            begin
                in_period_q    = since_pulse_q;
                period_valid_q = 1'b1;
            end
            since_pulse_q = '0;
            started_q     = 1'b1;
        end
        if (period_valid_q)
        begin
            divided = 64'(in_period_q) * division;
            period  = divided / mult;
            if (period < 1)
            begin
                period = 1;
            end
        end
        if (started_q)
        begin
            since_pulse_q = TIME_W'(sat_sum(64'(since_pulse_q), 64'(dt), TIME_MAX));
            if (pulse && div_count_q == 0)
            begin
                progress_q = '0;
            end
            else
            begin
                progress_q = (TIME_W+4)'(sat_sum(64'(progress_q), 64'(dt), PROG_MAX));
            end
            if (pulse)
            begin
                div_count_q = (64'(div_count_q) + 64'd1 >= division)
                            ? '0 : MAG_W'(div_count_q + 1);
            end
            if (period_valid_q && 64'(progress_q) < divided)
            begin
                r = 64'(progress_q) % period;
                if (2 * r <= period || r <= 64'(min_gate_q))
                begin
                    res.gate = 1'b1;
                end
            end
        end
        res.period = (period > 64'(ckmd_pkg::OUT_PERIOD_MAX))
                   ? ckmd_pkg::OUT_PERIOD_MAX : period[OUT_W-1:0];
        res.known  = period_valid_q;
        return res;
    endfunction

    task automatic send_item(input logic pulse, input logic [DT_W-1:0] dt,
                             input bit typed, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        clock_pulse   <= pulse;
        elapsed_ticks <= dt;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predicted = derive_gate(pulse, dt);
        expected_clock_out.push_back(typed ? want : predicted);
        items_in++;
        @(negedge clk);
    endtask

    // sender waits until every outstanding result has drained
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_clock_out.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_settings(input logic signed [RATIO_W-1:0] r,
                                  input logic [MIN_GATE_W-1:0] m);
        logic [CFG_DATA_W-1:0] word;
        settle();
        word = CFG_DATA_W'($urandom);
        word[RATIO_W-1:0] = r;
        cfg_we    <= 1'b1;
        cfg_index <= ckmd_pkg::REG_RATIO;
        cfg_data  <= word;
        ratio_q    = r;
        @(negedge clk);
        cfg_index <= ckmd_pkg::REG_MIN_GATE;
        cfg_data  <= m;
        min_gate_q = m;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (holds_done < hold_req)
            begin
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
                holds_done++;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{gate, effective_period, period_known};
            results_checked++;
            if (got.gate)
            begin
                gate_high_seen++;
            end
            if (int'(got.period) > longest_period_seen)
            begin
                longest_period_seen = int'(got.period);
            end
            if (expected_clock_out.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("%0t: unexpected transaction: gate %0b period %0d known %0b",
                             $time, got.gate, got.period, got.known);
                end
            end
            else
            begin
                want = expected_clock_out.pop_front();
                if (got.gate !== want.gate || got.period !== want.period ||
                    got.known !== want.known)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display({"%0t: mismatch: gate %0b/%0b period %0d/%0d",
                                  " known %0b/%0b (exp/act)"},
                                 $time, want.gate, got.gate, want.period, got.period,
                                 want.known, got.known);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int              phase_end;
        int              span;
        int              reps;
        int              style;
        bit              jitter;
        logic [DT_W-1:0] step;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        clock_pulse    = 1'b0;
        elapsed_ticks  = '0;
        cfg_we         = 1'b0;
        cfg_index      = ckmd_pkg::REG_RATIO;
        cfg_data       = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        hold_req       = 0;
        ratio_q        = ckmd_pkg::RATIO_RESET;
        min_gate_q     = ckmd_pkg::MIN_GATE_RESET;
        started_q      = 1'b0;
        since_pulse_q  = '0;
        in_period_q    = '0;
        period_valid_q = 1'b0;
        div_count_q    = '0;
        progress_q     = '0;

        directed_plan = '{
            '{ROW_TYPED, 1'b0, 4'd15, 6'h00, 16'd0,     '0},  // no clock yet
            '{ROW_TYPED, 1'b1, 4'd0,  6'h00, 16'd0,     '0},  // first pulse, no time
            '{ROW_TYPED, 1'b0, 4'd0,  6'h00, 16'd0,     '0},
            '{ROW_TYPED, 1'b1, 4'd3,  6'h00, 16'd0,     '0},  // second pulse, zero spacing
            '{ROW_ITEM,  1'b0, 4'd15, 6'h00, 16'd0,     '0},
            '{ROW_ITEM,  1'b1, 4'd1,  6'h00, 16'd0,     '0},
            '{ROW_ITEM,  1'b0, 4'd1,  6'h00, 16'd0,     '0},
            '{ROW_CFG,   1'b0, 4'd0,  6'h20, 16'd0,     '0},  // divide, saturates at 16
            '{ROW_ITEM,  1'b1, 4'd1,  6'h00, 16'd0,     '0},
            '{ROW_ITEM,  1'b0, 4'd15, 6'h00, 16'd0,     '0},
            '{ROW_ITEM,  1'b1, 4'd15, 6'h00, 16'd0,     '0},
            '{ROW_CFG,   1'b0, 4'd0,  6'h1F, 16'hFFFF,  '0},  // multiply, saturates at 16
            '{ROW_ITEM,  1'b1, 4'd1,  6'h00, 16'd0,     '0},
            '{ROW_ITEM,  1'b1, 4'd1,  6'h00, 16'd0,     '0},  // period under one tick
            '{ROW_ITEM,  1'b0, 4'd1,  6'h00, 16'd0,     '0},
            '{ROW_CFG,   1'b0, 4'd0,  6'h00, 16'd48,    '0},  // pass through
            '{ROW_ITEM,  1'b1, 4'd7,  6'h00, 16'd0,     '0},
            '{ROW_ITEM,  1'b0, 4'd15, 6'h00, 16'd0,     '0},
            '{ROW_ITEM,  1'b1, 4'd2,  6'h00, 16'd0,     '0},
            '{ROW_CFG,   1'b0, 4'd0,  6'h30, 16'hFFFF,  '0},
            '{ROW_ITEM,  1'b1, 4'd15, 6'h00, 16'd0,     '0},
            '{ROW_ITEM,  1'b0, 4'd15, 6'h00, 16'd0,     '0},
            '{ROW_CFG,   1'b0, 4'd0,  6'h10, 16'd0,     '0},
            '{ROW_ITEM,  1'b1, 4'd4,  6'h00, 16'd0,     '0},
            '{ROW_ITEM,  1'b0, 4'd10, 6'h00, 16'd0,     '0}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_CFG)
            begin
                write_settings(directed_plan[i].ratio_v, directed_plan[i].min_gate_v);
            end
            else
            begin
                send_item(directed_plan[i].pulse, directed_plan[i].dt,
                          directed_plan[i].kind == ROW_TYPED, directed_plan[i].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph < 7)
            begin
                write_settings(PHASE_RATIO[ph], PHASE_MIN_GATE[ph]);
            end
            else
            begin
                write_settings(RATIO_W'($urandom), MIN_GATE_W'($urandom_range(0, 200)));
            end
            case (ph % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 55;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 55;
                end
                default:
                begin
                    idle_pct  = 17;
                    stall_pct = 17;
                end
            endcase
            if (ph == 4 || ph == 8)
            begin
                hold_req++;
            end
            phase_end = items_in + PHASE_ITEMS;
            while (items_in < phase_end)
            begin
                style = $urandom_range(9);
                if (style == 9)
                begin
                    // noise: stray pulses, random spacing
                    repeat (12) send_item($urandom_range(3) == 0, DT_W'($urandom), 1'b0, '0);
                end
                else
                begin
                    span   = (style == 8) ? $urandom_range(60, 300) : $urandom_range(1, 24);
                    reps   = (style == 8) ? 2 : $urandom_range(2, 20);
                    jitter = ($urandom_range(3) == 0);
                    step   = (style < 5) ? DT_W'(1) : DT_W'($urandom);
                    repeat (reps)
                    begin
                        for (int k = 0; k < span && items_in < phase_end; k++)
                        begin
                            send_item(k == 0, jitter ? DT_W'($urandom) : step, 1'b0, '0);
                        end
                    end
                end
            end
        end

        idle_pct  = 0;
        stall_pct = 0;
        settle();

        $display("Run covered %0d transactions in, %0d results, %0d register settings,",
                 items_in, results_checked, settings_done);
        $display("%0d long holds; gate high in %0d results, longest period %0d ticks.",
                 holds_done, gate_high_seen, longest_period_seen);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
